/* rtl/core/twi_transaction_sequencer_top_macros.svh */
// assertion helpers shared by the sequencer files
`ifndef TWI_TRANSACTION_SEQUENCER_TOP_MACROS_SVH
`define TWI_TRANSACTION_SEQUENCER_TOP_MACROS_SVH

// checked on every clock edge outside reset
`define TWI_ASSERT(label, prop, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (prop)) else $error(msg);

// checked on every clock edge, reset included
`define TWI_ASSERT_ALWAYS(label, prop, msg) \
   label: assert property (@(posedge clock) (prop)) else $error(msg);

`endif

/* rtl/core/twi_seq_pkg.sv */
package twi_seq_pkg;

   // buffer geometry
   localparam int BufferDepth = 32;
   localparam int IndexWidth  = $clog2(BufferDepth);
   localparam int CountWidth  = 6;
   localparam logic [CountWidth-1:0] DepthCount = CountWidth'(BufferDepth);

   // commands
   localparam logic [2:0] CmdLoad     = 3'd0;
   localparam logic [2:0] CmdBeginWr  = 3'd1;
   localparam logic [2:0] CmdBeginRd  = 3'd2;
   localparam logic [2:0] CmdEvent    = 3'd3;
   localparam logic [2:0] CmdAppend   = 3'd4;
   localparam logic [2:0] CmdClear    = 3'd5;

   // bus status codes from the engine
   localparam logic [4:0] StStart     = 5'd0;
   localparam logic [4:0] StRepStart  = 5'd1;
   localparam logic [4:0] StMtAddrAck = 5'd2;
   localparam logic [4:0] StMtDataAck = 5'd3;
   localparam logic [4:0] StMtAddrNak = 5'd4;
   localparam logic [4:0] StMtDataNak = 5'd5;
   localparam logic [4:0] StMrAddrAck = 5'd6;
   localparam logic [4:0] StMrDataAck = 5'd7;
   localparam logic [4:0] StMrAddrNak = 5'd8;
   localparam logic [4:0] StMrDataNak = 5'd9;
   localparam logic [4:0] StArbLost   = 5'd10;
   localparam logic [4:0] StSrAddr    = 5'd11;
   localparam logic [4:0] StSrDataAck = 5'd12;
   localparam logic [4:0] StSrDataNak = 5'd13;
   localparam logic [4:0] StSrStop    = 5'd14;
   localparam logic [4:0] StStAddr    = 5'd15;
   localparam logic [4:0] StStDataAck = 5'd16;
   localparam logic [4:0] StStDataNak = 5'd17;

   // bus actions
   localparam logic [2:0] ActNone     = 3'd0;
   localparam logic [2:0] ActAck      = 3'd1;
   localparam logic [2:0] ActNack     = 3'd2;
   localparam logic [2:0] ActStop     = 3'd3;
   localparam logic [2:0] ActRepStart = 3'd4;
   localparam logic [2:0] ActRelease  = 3'd5;
   localparam logic [2:0] ActStart    = 3'd6;

   // notices
   localparam logic [2:0] NtcNone     = 3'd0;
   localparam logic [2:0] NtcMrxByte  = 3'd1;
   localparam logic [2:0] NtcMdone    = 3'd2;
   localparam logic [2:0] NtcSrxByte  = 3'd3;
   localparam logic [2:0] NtcSrxDone  = 3'd4;
   localparam logic [2:0] NtcStxDone  = 3'd5;
   localparam logic [2:0] NtcReject   = 3'd6;

   // error codes
   localparam logic [2:0] ErrOk       = 3'd0;
   localparam logic [2:0] ErrAddrNack = 3'd1;
   localparam logic [2:0] ErrDataNack = 3'd2;
   localparam logic [2:0] ErrArbLost  = 3'd3;
   localparam logic [2:0] ErrLength   = 3'd4;
   localparam logic [2:0] ErrBusy     = 3'd5;

   // sequencer modes
   localparam logic [2:0] ModeReady   = 3'd0;
   localparam logic [2:0] ModeMtx     = 3'd1;
   localparam logic [2:0] ModeMrx     = 3'd2;
   localparam logic [2:0] ModeSrx     = 3'd3;
   localparam logic [2:0] ModeStx     = 3'd4;

   typedef struct packed {
      logic [2:0]            command;
      logic [4:0]            bus_status;
      logic [6:0]            target_address;
      logic [CountWidth-1:0] byte_length;
      logic                  stop_at_end;
      logic [IndexWidth-1:0] byte_index;
      logic [7:0]            data_byte;
   } req_type;

   typedef struct packed {
      logic [2:0]            bus_action;
      logic                  drive_valid;
      logic [7:0]            drive_byte;
      logic [2:0]            notice;
      logic [7:0]            notice_byte;
      logic [CountWidth-1:0] byte_count;
      logic [2:0]            error_code;
      logic                  bus_ready;
   } rsp_type;

endpackage

/* rtl/core/twi_seq_engine.sv */
`include "twi_transaction_sequencer_top_macros.svh"

module twi_seq_engine
   import twi_seq_pkg::*;
(
   input  logic    clock,
   input  logic    reset,
   input  logic    step_en,
   input  req_type req,
   output rsp_type rsp
);

   // sequencer state
   logic [2:0]            mode_ff, mode_in;
   logic [1:0]            last_error_ff, last_error_in;
   logic [7:0]            addr_dir_ff, addr_dir_in;
   logic                  stop_wanted_ff, stop_wanted_in;
   logic                  rs_held_ff, rs_held_in;
   logic [CountWidth-1:0] m_pos_ff, m_pos_in;
   logic [CountWidth-1:0] m_limit_ff, m_limit_in;
   logic [CountWidth-1:0] stx_pos_ff, stx_pos_in;
   logic [CountWidth-1:0] stx_count_ff, stx_count_in;
   logic [CountWidth-1:0] srx_count_ff, srx_count_in;

   // transmit stores, no reset
   logic [7:0] master_mem_ff [BufferDepth];
   logic [7:0] stx_mem_ff [BufferDepth];
   logic       master_we, stx_we;

   // decision for the current transaction
   always_comb begin
      logic [CountWidth-1:0] pos_tmp;
      logic                  master_end;
      rsp           = '0;
      mode_in       = mode_ff;
      last_error_in = last_error_ff;
      addr_dir_in   = addr_dir_ff;
      stop_wanted_in = stop_wanted_ff;
      rs_held_in    = rs_held_ff;
      m_pos_in      = m_pos_ff;
      m_limit_in    = m_limit_ff;
      stx_pos_in    = stx_pos_ff;
      stx_count_in  = stx_count_ff;
      srx_count_in  = srx_count_ff;
      master_we     = 1'b0;
      stx_we        = 1'b0;
      master_end    = 1'b0;
      pos_tmp       = '0;

      unique case (req.command)
         CmdLoad: begin
            master_we = 1'b1;
         end
         CmdBeginWr, CmdBeginRd: begin
            if (mode_ff != ModeReady) begin
               rsp.notice     = NtcReject;
               rsp.error_code = ErrBusy;
            end else if (req.byte_length > DepthCount ||
                         (req.command == CmdBeginRd && req.byte_length == '0)) begin
               rsp.notice     = NtcReject;
               rsp.error_code = ErrLength;
            end else begin
               mode_in        = (req.command == CmdBeginWr) ? ModeMtx : ModeMrx;
               last_error_in  = '0;
               stop_wanted_in = req.stop_at_end;
               m_pos_in       = '0;
               m_limit_in     = (req.command == CmdBeginWr) ? req.byte_length
                                : req.byte_length - CountWidth'(1);
               addr_dir_in    = {req.target_address, req.command == CmdBeginRd};
               if (rs_held_ff) begin
                  rs_held_in      = 1'b0;
                  rsp.drive_valid = 1'b1;
                  rsp.drive_byte  = addr_dir_in;
                  rsp.bus_action  = ActAck;
               end else begin
                  rsp.bus_action  = ActStart;
               end
            end
         end
         CmdEvent: begin
            case (req.bus_status) inside
               StStart, StRepStart: begin
                  rsp.drive_valid = 1'b1;
                  rsp.drive_byte  = addr_dir_ff;
                  rsp.bus_action  = ActAck;
               end
               StMtAddrAck, StMtDataAck: begin
                  if (m_pos_ff < m_limit_ff && m_pos_ff < DepthCount) begin
                     rsp.drive_valid = 1'b1;
                     rsp.drive_byte  = master_mem_ff[m_pos_ff[IndexWidth-1:0]];
                     rsp.bus_action  = ActAck;
                     m_pos_in        = m_pos_ff + CountWidth'(1);
                  end else begin
                     rsp.byte_count = m_pos_ff;
                     master_end     = 1'b1;
                  end
               end
               StMtAddrNak, StMrAddrNak, StMtDataNak: begin
                  last_error_in  = (req.bus_status == StMtDataNak) ? ErrDataNack[1:0]
                                   : ErrAddrNack[1:0];
                  rsp.byte_count = m_pos_ff;
                  master_end     = 1'b1;
               end
               StMrDataAck: begin
                  rsp.notice      = NtcMrxByte;
                  rsp.notice_byte = req.data_byte;
                  rsp.byte_count  = m_pos_ff;
                  pos_tmp = (m_pos_ff < DepthCount) ? m_pos_ff + CountWidth'(1) : m_pos_ff;
                  m_pos_in        = pos_tmp;
                  rsp.bus_action  = (pos_tmp < m_limit_ff) ? ActAck : ActNack;
               end
               StMrAddrAck: begin
                  rsp.bus_action = (m_pos_ff < m_limit_ff) ? ActAck : ActNack;
               end
               StMrDataNak: begin
                  pos_tmp = (m_pos_ff < DepthCount) ? m_pos_ff + CountWidth'(1) : m_pos_ff;
                  m_pos_in        = pos_tmp;
                  rsp.byte_count  = pos_tmp;
                  rsp.notice_byte = req.data_byte;
                  master_end      = 1'b1;
               end
               StArbLost: begin
                  last_error_in  = ErrArbLost[1:0];
                  rsp.bus_action = ActRelease;
                  mode_in        = ModeReady;
                  rsp.notice     = NtcMdone;
                  rsp.byte_count = m_pos_ff;
                  rsp.error_code = ErrArbLost;
               end
               StSrAddr: begin
                  mode_in        = ModeSrx;
                  srx_count_in   = '0;
                  rsp.bus_action = ActAck;
               end
               StSrDataAck: begin
                  if (srx_count_ff < DepthCount) begin
                     rsp.notice      = NtcSrxByte;
                     rsp.notice_byte = req.data_byte;
                     rsp.byte_count  = srx_count_ff;
                     srx_count_in    = srx_count_ff + CountWidth'(1);
                     rsp.bus_action  = ActAck;
                  end else begin
                     rsp.bus_action  = ActNack;
                  end
               end
               StSrDataNak: begin
                  rsp.bus_action = ActNack;
               end
               StSrStop: begin
                  rsp.bus_action = ActRelease;
                  mode_in        = ModeReady;
                  rsp.notice     = NtcSrxDone;
                  rsp.byte_count = srx_count_ff;
               end
               StStAddr, StStDataAck: begin
                  // addressed as slave transmitter restarts from the first byte
                  pos_tmp = (req.bus_status == StStAddr) ? '0 : stx_pos_ff;
                  if (req.bus_status == StStAddr) begin
                     mode_in = ModeStx;
                  end
                  rsp.drive_valid = 1'b1;
                  stx_pos_in      = pos_tmp;
                  if (pos_tmp < stx_count_ff && pos_tmp < DepthCount) begin
                     rsp.drive_byte = stx_mem_ff[pos_tmp[IndexWidth-1:0]];
                     stx_pos_in     = pos_tmp + CountWidth'(1);
                     rsp.bus_action = (stx_pos_in < stx_count_ff) ? ActAck : ActNack;
                  end else begin
                     rsp.bus_action = ActNack;
                  end
               end
               StStDataNak: begin
                  rsp.bus_action = ActAck;
                  mode_in        = ModeReady;
                  rsp.notice     = NtcStxDone;
                  rsp.byte_count = stx_pos_ff;
                  stx_pos_in     = '0;
                  stx_count_in   = '0;
               end
               default: begin
               end
            endcase
         end
         CmdAppend: begin
            if (stx_count_ff < DepthCount) begin
               stx_we       = 1'b1;
               stx_count_in = stx_count_ff + CountWidth'(1);
            end else begin
               rsp.notice     = NtcReject;
               rsp.error_code = ErrLength;
            end
         end
         CmdClear: begin
            stx_count_in = '0;
            stx_pos_in   = '0;
         end
         default: begin
         end
      endcase

      // end of a master transaction: stop or hold the bus
      if (master_end) begin
         mode_in        = ModeReady;
         rsp.notice     = NtcMdone;
         rsp.error_code = {1'b0, last_error_in};
         if (stop_wanted_ff && req.bus_status != StMtAddrNak) begin
            rsp.bus_action = ActStop;
         end else if (req.bus_status == StMtAddrNak || req.bus_status == StMrAddrNak ||
                      req.bus_status == StMtDataNak) begin
            rsp.bus_action = ActStop;
            rs_held_in     = 1'b0;
         end else begin
            rsp.bus_action = ActRepStart;
            rs_held_in     = 1'b1;
         end
         if (req.bus_status == StMtAddrNak || req.bus_status == StMrAddrNak ||
             req.bus_status == StMtDataNak) begin
            rs_held_in = 1'b0;
         end
      end

      rsp.bus_ready = (mode_in == ModeReady);
   end

   // control state
   always_ff @(posedge clock) begin
      if (reset) begin
         mode_ff        <= ModeReady;
         last_error_ff  <= '0;
         addr_dir_ff    <= '0;
         stop_wanted_ff <= 1'b1;
         rs_held_ff     <= 1'b0;
         m_pos_ff       <= '0;
         m_limit_ff     <= '0;
         stx_pos_ff     <= '0;
         stx_count_ff   <= '0;
         srx_count_ff   <= '0;
      end else if (step_en) begin
         mode_ff        <= mode_in;
         last_error_ff  <= last_error_in;
         addr_dir_ff    <= addr_dir_in;
         stop_wanted_ff <= stop_wanted_in;
         rs_held_ff     <= rs_held_in;
         m_pos_ff       <= m_pos_in;
         m_limit_ff     <= m_limit_in;
         stx_pos_ff     <= stx_pos_in;
         stx_count_ff   <= stx_count_in;
         srx_count_ff   <= srx_count_in;
      end
   end

   // transmit store writes
   always_ff @(posedge clock) begin
      if (step_en && master_we) begin
         master_mem_ff[req.byte_index] <= req.data_byte;
      end
      if (step_en && stx_we) begin
         stx_mem_ff[stx_count_ff[IndexWidth-1:0]] <= req.data_byte;
      end
   end

   `TWI_ASSERT(a_master_pos_bound, m_pos_ff <= DepthCount, "master position beyond buffer")
   `TWI_ASSERT(a_stx_count_bound, stx_count_ff <= DepthCount && stx_pos_ff <= DepthCount,
      "slave transmit count beyond buffer")
   `TWI_ASSERT(a_srx_count_bound, srx_count_ff <= DepthCount, "slave receive count beyond buffer")

endmodule

/* rtl/core/twi_transaction_sequencer_top.sv */
// channel   ports                       moves
// req       req_valid/ready/payload     one command or bus status transaction
// rsp       rsp_valid/ready/payload     one decision per request transaction
// csr       csr_write_enable/data       own seven-bit slave address
//
// every request transaction is decided in the cycle it is accepted and its result is
// registered in the output or skid entry; one transaction per cycle while rsp_ready is high.
// a two-entry result buffer (output register plus skid) keeps req_ready high while
// one result waits; req_ready drops only when both entries are full.
// synchronous reset returns the sequencer to ready with empty buffers; no clearing pass.

`include "twi_transaction_sequencer_top_macros.svh"

module twi_transaction_sequencer_top
   import twi_seq_pkg::*;
(
   input  logic       clock,
   input  logic       reset,
   input  logic       req_valid,
   output logic       req_ready,
   input  req_type    req_payload,
   output logic       rsp_valid,
   input  logic       rsp_ready,
   output rsp_type    rsp_payload,
   input  logic       csr_write_enable,
   input  logic [6:0] csr_write_data
);

   logic       req_accept;
   logic       rsp_pop;
   rsp_type    decision;
   rsp_type    out_ff, skid_ff;
   logic       out_valid_ff, skid_valid_ff;
   logic [6:0] own_address_ff;

   assign req_ready  = !skid_valid_ff;
   assign req_accept = req_valid && req_ready;
   assign rsp_pop    = out_valid_ff && rsp_ready;

   twi_seq_engine u_engine (
      .clock   (clock),
      .reset   (reset),
      .step_en (req_accept),
      .req     (req_payload),
      .rsp     (decision)
   );

   // own address register; nothing in the engine reads it
   always_ff @(posedge clock) begin
      if (reset) begin
         own_address_ff <= '0;
      end else if (csr_write_enable) begin
         own_address_ff <= csr_write_data;
      end
   end

   // result buffer valid flags
   always_ff @(posedge clock) begin
      if (reset) begin
         out_valid_ff  <= 1'b0;
         skid_valid_ff <= 1'b0;
      end else if (rsp_pop) begin
         if (skid_valid_ff) begin
            skid_valid_ff <= 1'b0;
         end else begin
            out_valid_ff  <= req_accept;
         end
      end else if (req_accept) begin
         if (out_valid_ff) begin
            skid_valid_ff <= 1'b1;
         end else begin
            out_valid_ff  <= 1'b1;
         end
      end
   end

   // result buffer payload
   always_ff @(posedge clock) begin
      if (rsp_pop) begin
         if (skid_valid_ff) begin
            out_ff <= skid_ff;
         end else if (req_accept) begin
            out_ff <= decision;
         end
      end else if (req_accept) begin
         if (out_valid_ff) begin
            skid_ff <= decision;
         end else begin
            out_ff  <= decision;
         end
      end
   end

   assign rsp_valid   = out_valid_ff;
   assign rsp_payload = out_ff;

   `TWI_ASSERT(a_skid_needs_out, !skid_valid_ff || out_valid_ff,
      "skid entry held without output entry")
   `TWI_ASSERT(a_stall_fills_skid, (req_accept && out_valid_ff && !rsp_ready) |=> skid_valid_ff,
      "stalled transaction not parked in skid")
   `TWI_ASSERT(a_addr_holds, !csr_write_enable |=> $stable(own_address_ff),
      "own address changed without a write")

endmodule

/* tb/testbench.sv */
`timescale 1ns / 1ps

module testbench;
   import twi_seq_pkg::*;

   // codes the block leaves unused
   localparam logic [2:0] CmdUnused = 3'd7;
   localparam logic [4:0] StUnused  = 5'd31;

   logic    clock;
   logic    reset;
   logic    req_valid;
   logic    req_ready;
   req_type req_payload;
   logic    rsp_valid;
   logic    rsp_ready;
   rsp_type rsp_payload;
   logic    csr_write_enable;
   logic [6:0] csr_write_data;

   // predicted sequencer state
   logic [2:0] seq_mode;
   logic [2:0] seq_last_err;
   logic [7:0] seq_addr_dir;
   logic       seq_stop_wanted;
   logic       seq_rep_held;
   logic [7:0] mtx_store [BufferDepth];
   int         mtx_pos;
   int         mtx_limit;
   logic [7:0] stx_store [BufferDepth];
   int         stx_pos;
   int         stx_count;
   int         srx_count;

   rsp_type decision_q [$];
   int      transactions_sent;
   int      mismatch_count;
   bit      gaps_on;
   bit      stalls_on;
   int      hold_request;

   twi_transaction_sequencer_top dut (
      .clock            (clock),
      .reset            (reset),
      .req_valid        (req_valid),
      .req_ready        (req_ready),
      .req_payload      (req_payload),
      .rsp_valid        (rsp_valid),
      .rsp_ready        (rsp_ready),
      .rsp_payload      (rsp_payload),
      .csr_write_enable (csr_write_enable),
      .csr_write_data   (csr_write_data)
   );

   initial begin
      clock = 1'b0;
      forever #6 clock = ~clock;
   end

   // ---------------------------------------------------------------
   // decision predictor
   // ---------------------------------------------------------------

   task automatic reset_prediction();
      seq_mode        = ModeReady;
      seq_last_err    = ErrOk;
      seq_addr_dir    = 8'h00;
      seq_stop_wanted = 1'b1;
      seq_rep_held    = 1'b0;
      mtx_pos         = 0;
      mtx_limit       = 0;
      stx_pos         = 0;
      stx_count       = 0;
      srx_count       = 0;
   endtask

   // close a master transaction with stop or a held repeated start
   function automatic void finish_master(inout rsp_type r);
      if (seq_stop_wanted) begin
         r.bus_action = ActStop;
      end else begin
         r.bus_action = ActRepStart;
         seq_rep_held = 1'b1;
      end
      seq_mode     = ModeReady;
      r.notice     = NtcMdone;
      r.error_code = seq_last_err;
   endfunction

   // next slave transmit byte, zero with nack once the store runs dry
   function automatic void drive_slave_byte(inout rsp_type r);
      r.drive_valid = 1'b1;
      if (stx_pos < stx_count && stx_pos < BufferDepth) begin
         r.drive_byte = stx_store[stx_pos];
         stx_pos++;
         r.bus_action = (stx_pos < stx_count) ? ActAck : ActNack;
      end else begin
         r.drive_byte = 8'h00;
         r.bus_action = ActNack;
      end
   endfunction

   function automatic rsp_type predict_decision(input req_type t);
      rsp_type r;
      r = '0;
      case (t.command)
         CmdLoad: begin
            mtx_store[t.byte_index] = t.data_byte;
         end
         CmdBeginWr, CmdBeginRd: begin
            if (seq_mode != ModeReady) begin
               r.notice     = NtcReject;
               r.error_code = ErrBusy;
            end else if (int'(t.byte_length) > BufferDepth ||
                         (t.command == CmdBeginRd && t.byte_length == '0)) begin
               r.notice     = NtcReject;
               r.error_code = ErrLength;
            end else begin
               seq_mode        = (t.command == CmdBeginWr) ? ModeMtx : ModeMrx;
               seq_last_err    = ErrOk;
               seq_stop_wanted = t.stop_at_end;
               mtx_pos         = 0;
               mtx_limit       = (t.command == CmdBeginWr) ? int'(t.byte_length)
                                                           : int'(t.byte_length) - 1;
               seq_addr_dir    = {t.target_address, t.command == CmdBeginRd};
               // a held bus skips the start condition
               if (seq_rep_held) begin
                  seq_rep_held  = 1'b0;
                  r.drive_valid = 1'b1;
                  r.drive_byte  = seq_addr_dir;
                  r.bus_action  = ActAck;
               end else begin
                  r.bus_action = ActStart;
               end
            end
         end
         CmdEvent: begin
            case (t.bus_status)
               StStart, StRepStart: begin
                  r.drive_valid = 1'b1;
                  r.drive_byte  = seq_addr_dir;
                  r.bus_action  = ActAck;
               end
               StMtAddrAck, StMtDataAck: begin
                  if (mtx_pos < mtx_limit && mtx_pos < BufferDepth) begin
                     r.drive_valid = 1'b1;
                     r.drive_byte  = mtx_store[mtx_pos];
                     r.bus_action  = ActAck;
                     mtx_pos++;
                  end else begin
                     r.byte_count = 6'(mtx_pos);
                     finish_master(r);
                  end
               end
               StMtAddrNak, StMrAddrNak, StMtDataNak: begin
                  seq_last_err = (t.bus_status == StMtDataNak) ? ErrDataNack : ErrAddrNack;
                  r.byte_count = 6'(mtx_pos);
                  finish_master(r);
                  r.bus_action = ActStop;
                  seq_rep_held = 1'b0;
               end
               StMrAddrAck: begin
                  r.bus_action = (mtx_pos < mtx_limit) ? ActAck : ActNack;
               end
               StMrDataAck: begin
                  r.notice      = NtcMrxByte;
                  r.notice_byte = t.data_byte;
                  r.byte_count  = 6'(mtx_pos);
                  if (mtx_pos < BufferDepth) mtx_pos++;
                  r.bus_action  = (mtx_pos < mtx_limit) ? ActAck : ActNack;
               end
               StMrDataNak: begin
                  if (mtx_pos < BufferDepth) mtx_pos++;
                  r.byte_count = 6'(mtx_pos);
                  finish_master(r);
                  r.notice_byte = t.data_byte;
               end
               StArbLost: begin
                  seq_last_err = ErrArbLost;
                  r.bus_action = ActRelease;
                  seq_mode     = ModeReady;
                  r.notice     = NtcMdone;
                  r.byte_count = 6'(mtx_pos);
                  r.error_code = seq_last_err;
               end
               StSrAddr: begin
                  seq_mode     = ModeSrx;
                  srx_count    = 0;
                  r.bus_action = ActAck;
               end
               StSrDataAck: begin
                  // past a full buffer the byte is dropped and nacked
                  if (srx_count < BufferDepth) begin
                     r.notice      = NtcSrxByte;
                     r.notice_byte = t.data_byte;
                     r.byte_count  = 6'(srx_count);
                     srx_count++;
                     r.bus_action  = ActAck;
                  end else begin
                     r.bus_action = ActNack;
                  end
               end
               StSrDataNak: begin
                  r.bus_action = ActNack;
               end
               StSrStop: begin
                  r.bus_action = ActRelease;
                  seq_mode     = ModeReady;
                  r.notice     = NtcSrxDone;
                  r.byte_count = 6'(srx_count);
               end
               StStAddr: begin
                  seq_mode = ModeStx;
                  stx_pos  = 0;
                  drive_slave_byte(r);
               end
               StStDataAck: begin
                  drive_slave_byte(r);
               end
               StStDataNak: begin
                  r.bus_action = ActAck;
                  seq_mode     = ModeReady;
                  r.notice     = NtcStxDone;
                  r.byte_count = 6'(stx_pos);
                  stx_pos      = 0;
                  stx_count    = 0;
               end
               default: ;
            endcase
         end
         CmdAppend: begin
            if (stx_count < BufferDepth) begin
               stx_store[stx_count] = t.data_byte;
               stx_count++;
            end else begin
               r.notice     = NtcReject;
               r.error_code = ErrLength;
            end
         end
         CmdClear: begin
            stx_count = 0;
            stx_pos   = 0;
         end
         default: ;
      endcase
      r.bus_ready = (seq_mode == ModeReady);
      return r;
   endfunction

   // ---------------------------------------------------------------
   // request side
   // ---------------------------------------------------------------

   function automatic req_type random_fields();
      logic [63:0] raw;
      raw = {$urandom, $urandom};
      return raw[$bits(req_type)-1:0];
   endfunction

   // offer one transaction, predict its decision once accepted
   task automatic send_transaction(input req_type t);
      @(negedge clock);
      while (gaps_on && $urandom_range(99) < 25) begin
         req_valid <= 1'b0;
         @(negedge clock);
      end
      req_payload <= t;
      req_valid   <= 1'b1;
      do @(posedge clock); while (!req_ready);
      decision_q.push_back(predict_decision(t));
      transactions_sent++;
   endtask

   task automatic send_plain(input logic [2:0] cmd);
      req_type t;
      t = random_fields();
      t.command = cmd;
      send_transaction(t);
   endtask

   task automatic send_event(input logic [4:0] status, input logic [7:0] data);
      req_type t;
      t = random_fields();
      t.command    = CmdEvent;
      t.bus_status = status;
      t.data_byte  = data;
      send_transaction(t);
   endtask

   task automatic send_begin(input logic [2:0] cmd, input logic [6:0] addr, input int len,
                             input logic stop);
      req_type t;
      t = random_fields();
      t.command        = cmd;
      t.target_address = addr;
      t.byte_length    = 6'(len);
      t.stop_at_end    = stop;
      send_transaction(t);
   endtask

   task automatic send_load(input int idx, input logic [7:0] data);
      req_type t;
      t = random_fields();
      t.command    = CmdLoad;
      t.byte_index = 5'(idx);
      t.data_byte  = data;
      send_transaction(t);
   endtask

   task automatic send_append(input logic [7:0] data);
      req_type t;
      t = random_fields();
      t.command   = CmdAppend;
      t.data_byte = data;
      send_transaction(t);
   endtask

   // stop offering and wait for every pending decision
   task automatic drain_decisions();
      @(negedge clock);
      req_valid <= 1'b0;
      while (decision_q.size() != 0) @(negedge clock);
   endtask

   task automatic write_own_address(input logic [6:0] value);
      @(negedge clock);
      csr_write_enable <= 1'b1;
      csr_write_data   <= value;
      @(negedge clock);
      csr_write_enable <= 1'b0;
   endtask

   // ---------------------------------------------------------------
   // well-formed bus sequences with random content
   // ---------------------------------------------------------------

   // mostly bring a busy sequencer back to ready before a begin
   task automatic settle_mode();
      if (seq_mode != ModeReady && $urandom_range(3) != 0) send_event(StSrStop, 8'($urandom));
   endtask

   task automatic run_master_write();
      int len;
      int roll;
      roll = $urandom_range(99);
      if (roll < 5) len = $urandom_range(63, 33);
      else if (roll < 12) len = BufferDepth;
      else len = $urandom_range(6);
      settle_mode();
      send_begin(CmdBeginWr, 7'($urandom), len, 1'($urandom));
      if (len > BufferDepth) return;
      send_event($urandom_range(1) ? StStart : StRepStart, 8'($urandom));
      roll = $urandom_range(99);
      if (roll < 8) begin
         send_event(StMtAddrNak, 8'($urandom));
         return;
      end
      if (roll < 12) begin
         send_event(StArbLost, 8'($urandom));
         return;
      end
      send_event(StMtAddrAck, 8'($urandom));
      for (int i = 0; i < len; i++) begin
         if ($urandom_range(99) < 3) begin
            send_event(StMtDataNak, 8'($urandom));
            return;
         end
         if ($urandom_range(99) < 5) send_load($urandom_range(BufferDepth - 1), 8'($urandom));
         send_event(StMtDataAck, 8'($urandom));
      end
   endtask

   task automatic run_master_read();
      int len;
      int roll;
      roll = $urandom_range(99);
      if (roll < 5) len = 0;
      else if (roll < 10) len = $urandom_range(63, 33);
      else if (roll < 16) len = BufferDepth;
      else len = $urandom_range(8, 1);
      settle_mode();
      send_begin(CmdBeginRd, 7'($urandom), len, 1'($urandom));
      if (len == 0 || len > BufferDepth) return;
      send_event($urandom_range(1) ? StStart : StRepStart, 8'($urandom));
      roll = $urandom_range(99);
      if (roll < 8) begin
         send_event(StMrAddrNak, 8'($urandom));
         return;
      end
      if (roll < 11) begin
         send_event(StArbLost, 8'($urandom));
         return;
      end
      send_event(StMrAddrAck, 8'($urandom));
      for (int i = 1; i < len; i++) begin
         if ($urandom_range(99) < 3) begin
            send_event(StArbLost, 8'($urandom));
            return;
         end
         send_event(StMrDataAck, 8'($urandom));
      end
      send_event(StMrDataNak, 8'($urandom));
   endtask

   task automatic run_slave_receive();
      int count;
      count = ($urandom_range(99) < 8) ? $urandom_range(40, 33) : $urandom_range(6);
      send_event(StSrAddr, 8'($urandom));
      for (int i = 0; i < count; i++) send_event(StSrDataAck, 8'($urandom));
      if ($urandom_range(99) < 20) send_event(StSrDataNak, 8'($urandom));
      send_event(StSrStop, 8'($urandom));
   endtask

   task automatic run_slave_transmit();
      int count;
      if ($urandom_range(1)) send_plain(CmdClear);
      count = ($urandom_range(99) < 8) ? $urandom_range(36, 30) : $urandom_range(5);
      for (int i = 0; i < count; i++) send_append(8'($urandom));
      send_event(StStAddr, 8'($urandom));
      count = $urandom_range(count + 1);
      for (int i = 0; i < count; i++) send_event(StStDataAck, 8'($urandom));
      send_event(StStDataNak, 8'($urandom));
   endtask

   task automatic run_random_mix(input int goal);
      int pick;
      while (transactions_sent < goal) begin
         pick = $urandom_range(99);
         if (pick < 20) run_master_write();
         else if (pick < 40) run_master_read();
         else if (pick < 55) run_slave_receive();
         else if (pick < 70) run_slave_transmit();
         else repeat ($urandom_range(4, 1)) send_transaction(random_fields());
      end
   endtask

   // ---------------------------------------------------------------
   // tests
   // ---------------------------------------------------------------

   // load, begin and event commands, field extremes, master write then read on a held bus
   task automatic test_directed_commands();
      send_load(0, 8'h00);
      send_load(1, 8'hFF);
      send_load(BufferDepth - 1, 8'hA5);
      send_begin(CmdBeginWr, 7'h7F, 2, 1'b0);
      send_event(StStart, 8'h00);
      send_event(StMtAddrAck, 8'h00);
      send_event(StMtDataAck, 8'h00);
      send_event(StMtDataAck, 8'h00);
      send_begin(CmdBeginRd, 7'h00, 1, 1'b1);
      send_begin(CmdBeginWr, 7'h00, 0, 1'b1);
      send_event(StMrAddrAck, 8'h00);
      send_event(StMrDataNak, 8'hFF);
      send_begin(CmdBeginRd, 7'h00, 0, 1'b1);
      send_begin(CmdBeginWr, 7'h00, 63, 1'b1);
      send_begin(CmdBeginWr, 7'h55, 0, 1'b1);
      send_event(StMtAddrAck, 8'h00);
   endtask

   // address nack, events out of mode, empty slave store, slave rx, unused codes
   task automatic test_directed_special_cases();
      send_begin(CmdBeginRd, 7'h2A, BufferDepth, 1'b1);
      send_event(StMrAddrNak, 8'h00);
      send_event(StArbLost, 8'h00);
      send_event(StMtDataNak, 8'h00);
      send_plain(CmdClear);
      send_event(StStAddr, 8'h00);
      send_event(StStDataNak, 8'h00);
      send_event(StSrAddr, 8'h00);
      send_event(StSrDataAck, 8'h00);
      send_event(StSrDataNak, 8'hFF);
      send_event(StSrStop, 8'h00);
      send_plain(CmdUnused);
      send_event(StUnused, 8'h00);
   endtask

   task automatic test_master_write_sequences();
      int goal;
      // every master slot written before any random event can read one
      for (int i = 0; i < BufferDepth; i++) send_load(i, 8'($urandom));
      goal = transactions_sent + 250;
      while (transactions_sent < goal) begin
         if ($urandom_range(99) < 10) send_transaction(random_fields());
         else run_master_write();
      end
   endtask

   task automatic test_master_read_sequences();
      int goal;
      goal = transactions_sent + 250;
      while (transactions_sent < goal) begin
         if ($urandom_range(99) < 10) send_transaction(random_fields());
         else run_master_read();
      end
   endtask

   task automatic test_slave_receive_sequences();
      int goal;
      goal = transactions_sent + 200;
      while (transactions_sent < goal) run_slave_receive();
   endtask

   task automatic test_slave_transmit_sequences();
      int goal;
      goal = transactions_sent + 200;
      while (transactions_sent < goal) run_slave_transmit();
   endtask

   // receiver holds off while the sender keeps offering, then the sender pauses
   task automatic test_backpressure();
      gaps_on = 1'b0;
      hold_request = 80;
      run_random_mix(transactions_sent + 40);
      gaps_on = 1'b1;
      drain_decisions();
   endtask

   task automatic test_no_idle_stretch();
      gaps_on   = 1'b0;
      stalls_on = 1'b0;
      run_random_mix(transactions_sent + 250);
      gaps_on   = 1'b1;
      stalls_on = 1'b1;
   endtask

   task automatic test_random_mix();
      run_random_mix(transactions_sent + 450);
   endtask

   // ---------------------------------------------------------------
   // result side
   // ---------------------------------------------------------------

   // random stalls, always ready with stalls off, or a counted hold-off when one is requested
   initial begin
      int hold_left;
      hold_left = 0;
      rsp_ready = 1'b0;
      forever begin
         @(negedge clock);
         if (hold_request > 0) begin
            hold_left = hold_request;
            hold_request = 0;
         end
         if (hold_left > 0) begin
            hold_left--;
            rsp_ready <= 1'b0;
         end else if (!stalls_on) begin
            rsp_ready <= 1'b1;
         end else begin
            rsp_ready <= ($urandom_range(99) >= 25);
         end
      end
   end

   task automatic check_field(input string field, input logic [7:0] want,
                              input logic [7:0] got);
      if (got !== want) begin
         $display("%0t ns: %s mismatch, expected %0d, actual %0d", $time, field, want, got);
         mismatch_count++;
      end
   endtask

   // sample at the rising edge, compare once the edge has settled
   initial begin
      rsp_type got;
      rsp_type want;
      bit      fired;
      forever begin
         @(posedge clock);
         fired = rsp_valid === 1'b1 && rsp_ready === 1'b1 && !reset;
         got   = rsp_payload;
         if (fired) begin
            @(negedge clock);
            if (decision_q.size() == 0) begin
               $display("%0t ns: decision with none pending, expected nothing, actual %h",
                        $time, got);
               mismatch_count++;
            end else begin
               want = decision_q.pop_front();
               check_field("bus_action", 8'(want.bus_action), 8'(got.bus_action));
               check_field("drive_valid", 8'(want.drive_valid), 8'(got.drive_valid));
               check_field("drive_byte", want.drive_byte, got.drive_byte);
               check_field("notice", 8'(want.notice), 8'(got.notice));
               check_field("notice_byte", want.notice_byte, got.notice_byte);
               check_field("byte_count", 8'(want.byte_count), 8'(got.byte_count));
               check_field("error_code", 8'(want.error_code), 8'(got.error_code));
               check_field("bus_ready", 8'(want.bus_ready), 8'(got.bus_ready));
            end
         end
      end
   end

   // ---------------------------------------------------------------
   // run control
   // ---------------------------------------------------------------

   initial begin
      #4_800_000;
      $display("[FAIL] regression broken");
      $finish;
   end

   initial begin
      req_valid         = 1'b0;
      req_payload       = '0;
      csr_write_enable  = 1'b0;
      csr_write_data    = 7'h00;
      reset             = 1'b1;
      gaps_on           = 1'b1;
      stalls_on         = 1'b1;
      hold_request      = 0;
      transactions_sent = 0;
      mismatch_count    = 0;
      reset_prediction();
      repeat (10) @(negedge clock);
      reset <= 1'b0;

      write_own_address(7'h7F);
      test_directed_commands();
      test_directed_special_cases();
      drain_decisions();
      write_own_address(7'h00);
      test_master_write_sequences();
      drain_decisions();
      write_own_address(7'($urandom));
      test_master_read_sequences();
      drain_decisions();
      write_own_address(7'h7F);
      test_slave_receive_sequences();
      test_slave_transmit_sequences();
      test_backpressure();
      write_own_address(7'($urandom));
      test_no_idle_stretch();
      drain_decisions();
      write_own_address(7'h00);
      test_random_mix();
      drain_decisions();

      // let any stray decision show up before the verdict
      repeat (8) @(negedge clock);
      #1;
      if (mismatch_count == 0) begin
         $display("[ OK ] regression clean");
      end else begin
         $display("[FAIL] regression broken");
      end
      $finish;
   end

endmodule
